// ----- hw/rtl/rc4a85_pkg.sv -----
package rc4a85_pkg;
    localparam int KEY_BITS = 64;
    localparam int KeyIdxW  = $clog2(KEY_BITS);
    localparam logic [6:0] CHAR_BASE = 7'd33;
    localparam logic [6:0] RADIX     = 7'd85;
    localparam int N_DIGITS = 5;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_group;
endpackage

// ----- hw/rtl/rc4a85_cipher.sv -----
// Keystream engine: permutation RAM with one read port and one write port.
// Key schedule fills the table, then runs 256 steps through states KA, KB, KC and
// KD; each byte then passes through states EA, EB, EC, ED, EE and EF.
module rc4a85_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rc4a85_pkg::KEY_BITS-1:0] i_key,
    input  logic                       i_start,
    input  logic                       i_sched,
    input  logic [7:0]                 i_byte,
    output logic                       o_done,
    output logic [7:0]                 o_cipher
);
    import rc4a85_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_KA    = 4'd2;
    localparam logic [3:0] S_KB    = 4'd3;
    localparam logic [3:0] S_KC    = 4'd4;
    localparam logic [3:0] S_KD    = 4'd5;
    localparam logic [3:0] S_EA    = 4'd6;
    localparam logic [3:0] S_EB    = 4'd7;
    localparam logic [3:0] S_EC    = 4'd8;
    localparam logic [3:0] S_ED    = 4'd9;
    localparam logic [3:0] S_EE    = 4'd10;
    localparam logic [3:0] S_EF    = 4'd11;

    logic [7:0] r_mem [256];
    logic [7:0] r_rdata;
    logic [7:0] rd_addr;
    logic       we;
    logic [7:0] wa, wd;

    logic [3:0] r_state, n_state;
    logic [8:0] r_n, n_n;
    logic [7:0] r_i, n_i, r_j, n_j, r_si, n_si, r_sj, n_sj, r_b, n_b;
    logic [7:0] r_out, n_out;
    logic       r_done, n_done;
    logic       kb;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rdata <= r_mem[rd_addr];
    end

    assign kb = i_key[KeyIdxW'(r_n[7:0] % KEY_BITS)];

    always_comb begin
        n_state = r_state; n_n = r_n; n_i = r_i; n_j = r_j;
        n_si = r_si; n_sj = r_sj; n_b = r_b; n_out = r_out;
        n_done = 1'b0; we = 1'b0; wa = '0; wd = '0; rd_addr = '0;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                n_b = i_byte;
                if (i_sched) begin
                    n_state = S_FILL; n_n = '0;
                end else begin
                    n_i = r_i + 8'd1; n_state = S_EA;
                end
            end
            S_FILL: begin
                we = 1'b1; wa = r_n[7:0]; wd = r_n[7:0];
                n_n = r_n + 9'd1;
                if (r_n == 9'd255) begin
                    n_n = '0; n_j = '0; n_state = S_KA;
                end
            end
            S_KA: begin rd_addr = r_n[7:0]; n_state = S_KB; end
            S_KB: begin
                n_si = r_rdata;
                n_j = r_j + r_rdata + {7'd0, kb};
                rd_addr = n_j; n_state = S_KC;
            end
            S_KC: begin
                we = 1'b1; wa = r_n[7:0]; wd = r_rdata; n_state = S_KD;
            end
            S_KD: begin
                we = 1'b1; wa = r_j; wd = r_si;
                n_n = r_n + 9'd1;
                if (r_n == 9'd255) begin
                    n_i = 8'd1; n_state = S_EA;
                end else n_state = S_KA;
            end
            S_EA: begin rd_addr = r_i; n_state = S_EB; end
            S_EB: begin
                n_si = r_rdata; n_j = r_j + r_rdata; rd_addr = n_j;
                n_state = S_EC;
            end
            S_EC: begin
                n_sj = r_rdata;
                we = 1'b1; wa = r_i; wd = r_rdata; n_state = S_ED;
            end
            S_ED: begin
                we = 1'b1; wa = r_j; wd = r_si;
                n_state = S_EE;
            end
            // swap is complete here, so the keystream read sees the new table
            S_EE: begin rd_addr = r_si + r_sj; n_state = S_EF; end
            S_EF: begin
                n_out = r_b ^ r_rdata; n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_i <= '0; r_j <= '0; r_n <= '0; r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_i <= n_i; r_j <= n_j; r_n <= n_n;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si <= n_si; r_sj <= n_sj; r_b <= n_b;
        r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_cipher = r_out;
endmodule

// ----- hw/rtl/rc4a85_radix.sv -----
// Base-85 split: one digit per cycle by reciprocal multiply and correction.
module rc4a85_radix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rc4a85_pkg::t_group    i_group,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic [6:0]            o_char,
    output logic                  o_last,
    input  logic                  i_stall
);
    import rc4a85_pkg::*;

    logic [31:0] r_v;
    logic [6:0]  r_dig [N_DIGITS];
    logic [2:0]  r_cnt;
    logic        r_div, r_last, r_out;
    logic [63:0] prod;
    logic [31:0] q, rem;
    logic [31:0] q_fix;
    logic [6:0]  d_fix;

    // floor(2^38/85)+1 is exact for all 32-bit values within one correction
    assign prod = {32'd0, r_v} * 64'd3233857729;
    assign q    = {6'd0, prod[63:38]};
    assign rem  = r_v - q * 32'd85;
    always_comb begin
        if (rem >= 32'd85) begin
            q_fix = q + 32'd1; d_fix = 7'(rem - 32'd85);
        end else begin
            q_fix = q; d_fix = rem[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= 1'b0; r_out <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            r_div <= 1'b1; r_cnt <= '0;
        end else if (r_div) begin
            if (r_cnt == 3'(N_DIGITS - 1)) begin
                r_div <= 1'b0; r_out <= 1'b1; r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end else if (r_out && !i_stall) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'(N_DIGITS - 1)) r_out <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_group.word; r_last <= i_group.last;
        end else if (r_div) begin
            r_v <= q_fix;
            r_dig[3'(N_DIGITS - 1) - r_cnt] <= d_fix + CHAR_BASE;
        end
    end

    assign o_busy  = r_div | r_out;
    assign o_valid = r_out;
    assign o_char  = r_dig[r_cnt];
    assign o_last  = r_last && (r_cnt == 3'(N_DIGITS - 1));
endmodule

// ----- hw/rtl/rc4_variant_ascii85_encrypt_core.sv -----
// channel | dir | handshake        | payload
// in      | in  | valid / stall    | plain_byte, end_of_message
// out     | out | valid / stall    | armour_char, last_char
// cfg     | in  | valid / ready    | cipher_key (64 bits)
// First byte of a message adds the key schedule: the table fill, then 256 key steps.
// Each byte is encrypted before the next is accepted; each padding byte adds
// a pass through the cipher, paced by the single read port of the permutation RAM.
// A full group is then split into 5 base-85 digits, then 5 words go out.
// Reset is synchronous; the next byte is taken only after all 5 words leave.
module rc4_variant_ascii85_encrypt_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_plain_byte,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_armour_char,
    output logic       o_last_char,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [63:0] i_cfg_data
);
    import rc4a85_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ENC  = 2'd1;
    localparam logic [1:0] C_PAD  = 2'd2;
    localparam logic [1:0] C_EMIT = 2'd3;

    logic [1:0]  r_st;
    logic [KEY_BITS-1:0] r_key;
    logic        r_inmsg, r_eom, r_sched;
    logic [31:0] r_word;
    logic [1:0]  r_cnt;
    logic [7:0]  r_byte;
    logic        c_start, c_done, d_busy, d_start;
    logic [7:0]  c_out;
    t_group      grp;
    logic [31:0] new_word;
    logic        acc;

    assign acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_st != C_IDLE);
    assign o_cfg_ready = 1'b1;
    assign new_word = {r_word[23:0], c_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_key <= '0;
        else if (i_cfg_valid) r_key <= i_cfg_data[KEY_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE; r_inmsg <= 1'b0; r_cnt <= '0; r_word <= '0;
            r_eom <= 1'b0; r_sched <= 1'b0;
        end else begin
            unique case (r_st)
                C_IDLE: if (acc) begin
                    r_byte <= i_plain_byte; r_eom <= i_end_of_message;
                    r_sched <= !r_inmsg; r_inmsg <= 1'b1; r_st <= C_ENC;
                    if (!r_inmsg) begin
                        r_cnt <= '0; r_word <= '0;
                    end
                end
                C_ENC, C_PAD: if (c_done) begin
                    r_word <= new_word; r_cnt <= r_cnt + 2'd1;
                    r_sched <= 1'b0; r_byte <= '0;
                    if (r_cnt == 2'd3) r_st <= C_EMIT;
                    else if (r_eom) r_st <= C_PAD;
                    else r_st <= C_IDLE;
                end
                C_EMIT: if (!d_busy && !d_start) begin
                    r_st <= C_IDLE; r_word <= '0; r_cnt <= '0;
                    if (r_eom) r_inmsg <= 1'b0;
                end
                default: r_st <= C_IDLE;
            endcase
        end
    end

    logic r_kick;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kick <= 1'b0;
        else r_kick <= acc || ((r_st == C_ENC || r_st == C_PAD) && c_done
                               && r_cnt != 2'd3 && r_eom);
    end
    assign c_start = r_kick;

    logic r_dstart;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dstart <= 1'b0;
        else r_dstart <= (r_st != C_EMIT) && c_done && r_cnt == 2'd3;
    end
    assign d_start = r_dstart;
    assign grp.word = r_word;
    assign grp.last = r_eom;

    rc4a85_cipher u_cipher (
        .i_clk, .i_rst_n, .i_key(r_key), .i_start(c_start), .i_sched(r_sched),
        .i_byte(r_byte), .o_done(c_done), .o_cipher(c_out)
    );

    rc4a85_radix u_radix (
        .i_clk, .i_rst_n, .i_start(d_start), .i_group(grp), .o_busy(d_busy),
        .o_valid(o_out_valid), .o_char(o_armour_char), .o_last(o_last_char),
        .i_stall(i_out_stall)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != C_IDLE) |-> !acc) else $error("accept while busy");
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_st == C_EMIT)) else $error("output outside emit");
    a_last_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_char) |-> r_eom) else $error("stray last");
endmodule

// ----- bench/tb_rc4_variant_ascii85_encrypt_core.sv -----
`timescale 1ns / 100ps

module tb_rc4_variant_ascii85_encrypt_core;
    import rc4a85_pkg::*;

    typedef struct packed {
        logic [6:0] armour_char;
        logic       last_char;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_plain_byte = '0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [6:0]  o_armour_char;
    logic        o_last_char;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data = '0;

    // cipher shadow state
    logic [63:0] key_shadow;
    logic [7:0]  perm [256];
    logic [7:0]  ks_i, ks_j;
    logic [31:0] grp_word;
    int          grp_count;
    bit          msg_open;

    t_char       char_queue [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          n_err;
    int          n_chars;
    int          n_bytes;
    int          n_msgs;
    longint      cycles;

    localparam longint CYCLE_LIMIT = 3000000;

    rc4_variant_ascii85_encrypt_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] next_keystream();
        logic [7:0] t;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + perm[ks_i];
        t = perm[ks_i];
        perm[ks_i] = perm[ks_j];
        perm[ks_j] = t;
        return perm[8'(perm[ks_i] + perm[ks_j])];
    endfunction

    function automatic void schedule_key();
        logic [7:0] j, t;
        j = '0;
        for (int n = 0; n < 256; n++) perm[n] = 8'(n);
        for (int n = 0; n < 256; n++) begin
            j = j + perm[n] + 8'(key_shadow[n % KEY_BITS]);
            t = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        ks_i = '0;
        ks_j = j;
    endfunction

    function automatic void push_group(bit last);
        logic [31:0] v;
        t_char g [5];
        v = grp_word;
        for (int k = 4; k >= 0; k--) begin
            g[k].armour_char = 7'(CHAR_BASE + v % 85);
            g[k].last_char = 1'b0;
            v = v / 85;
        end
        g[4].last_char = last;
        for (int k = 0; k < 5; k++) char_queue.push_back(g[k]);
        grp_word = '0;
        grp_count = 0;
    endfunction

    function automatic void encrypt_byte(logic [7:0] b, bit eom);
        if (!msg_open) begin
            schedule_key();
            grp_word = '0;
            grp_count = 0;
            msg_open = 1;
        end
        grp_word = {grp_word[23:0], b ^ next_keystream()};
        grp_count++;
        if (eom) begin
            while (grp_count < 4) begin
                grp_word = {grp_word[23:0], 8'h00 ^ next_keystream()};
                grp_count++;
            end
            push_group(1);
            msg_open = 0;
            n_msgs++;
        end else if (grp_count >= 4) begin
            push_group(0);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_chars++;
            if (char_queue.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected char %0d last %0b", o_armour_char, o_last_char);
            end else begin
                t_char e;
                e = char_queue.pop_front();
                if (e.armour_char !== o_armour_char || e.last_char !== o_last_char) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("char mismatch: exp %0d/%0b got %0d/%0b",
                                 e.armour_char, e.last_char, o_armour_char, o_last_char);
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // valid stays up after an accept until the next word or an idle cycle
    task automatic send_byte(logic [7:0] b, bit eom);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_plain_byte <= b;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        encrypt_byte(b, eom);
        n_bytes++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (char_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_key(logic [63:0] k);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        key_shadow = k;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_message(int len);
        for (int n = 0; n < len; n++)
            send_byte(8'($urandom), n == len - 1);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // default key, short last groups of each length
        send_byte(8'h00, 1);
        send_byte(8'hFF, 0); send_byte(8'h00, 1);
        send_byte(8'hA5, 0); send_byte(8'h5A, 0); send_byte(8'hFF, 1);
        drain();
        write_key('1);
        send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 1);
        // full group then one more byte
        for (int n = 0; n < 5; n++) send_byte(8'(n * 51), n == 4);
        drain();
        write_key(64'h8000_0000_0000_0001);
        // key change mid-message applies to the next message
        send_byte(8'h01, 0); send_byte(8'h80, 0);
        drain();
        write_key(64'h0123_4567_89AB_CDEF);
        send_byte(8'h7F, 1);
        send_message(3);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int n_items);
        int sent;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_key({$urandom, $urandom});
        sent = 0;
        while (sent < n_items) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
            send_message(len);
            sent += len;
        end
        drain();
    endtask

    initial begin
        n_err = 0; n_chars = 0; n_bytes = 0; n_msgs = 0; cycles = 0;
        key_shadow = '0; ks_i = '0; ks_j = '0; grp_word = '0; grp_count = 0;
        msg_open = 0; send_idle_pct = 0; recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 50);
        test_random_phase(86, 0, 50);
        test_random_phase(0, 86, 50);
        test_random_phase(38, 38, 50);
        write_key('0);
        send_message(6);
        drain();
        $display("sent %0d bytes in %0d messages, checked %0d chars", n_bytes, n_msgs, n_chars);
        $display("keys incl. all-zero/all-one, stalls and idles on both sides");
        if (n_err == 0 && char_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("errors: %0d, pending: %0d", n_err, char_queue.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
